FILE: rtl/mscrc_pkg.sv
// ----------------------------------------------------------------------------
// mscrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the message
// segmenter.
// ----------------------------------------------------------------------------
package mscrc_pkg;

  // Packet geometry and message limits
  localparam int MAX_PACKETS  = 256;
  localparam int PACKET_BYTES = 8;
  localparam int SIZE_W       = 12;
  localparam int SIZE_LIMIT   = (MAX_PACKETS * PACKET_BYTES > (1 << SIZE_W) - 1) ?
                                ((1 << SIZE_W) - 1) : (MAX_PACKETS * PACKET_BYTES);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(SIZE_LIMIT);

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Queue between front and back
  localparam int QDEPTH = 2;

  // Input beat
  typedef struct packed {
    logic [7:0]        data_byte;
    logic [31:0]       src_id;
    logic [31:0]       dest_id;
    logic [SIZE_W-1:0] msg_size;
  } msg_t;

  // Output beat
  typedef struct packed {
    logic [7:0]  packet_index;
    logic [8:0]  total_packets;
    logic [31:0] src_id_out;
    logic [31:0] dest_id_out;
    logic [3:0]  data_length;
    logic [15:0] crc;
    logic [63:0] payload;
    logic        last_packet;
  } pkt_t;

  // Classified byte, handed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  pos;
    logic        close;
    logic        last;
    logic [7:0]  index;
    logic [8:0]  total;
    logic [31:0] src;
    logic [31:0] dest;
  } op_t;

  // Queue status towards the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One byte through the reflected CRC, eight bit steps
  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/mscrc_front.sv
// ----------------------------------------------------------------------------
// mscrc_front
// Accepts message bytes, samples the header on a message's first byte and
// tags each byte with its packet position, packet number and close flags.
// ----------------------------------------------------------------------------
module mscrc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_stall,
  input  mscrc_pkg::msg_t  msg,
  input  mscrc_pkg::q_stat_t q_stat,
  output logic             push,
  output mscrc_pkg::op_t   op
);

  logic [mscrc_pkg::SIZE_W-1:0] bytes_left, bytes_left_next;
  logic [2:0]  byte_in_packet;
  logic [7:0]  packet_count;
  logic [8:0]  total_latched;
  logic [31:0] src_latched, dest_latched;

  logic                         start;
  logic [mscrc_pkg::SIZE_W-1:0] size_sat, left_cur;
  logic [mscrc_pkg::SIZE_W:0]   size_round;
  logic [2:0]  pos;
  logic [7:0]  idx;
  logic [8:0]  total;
  logic [31:0] src, dest;
  logic        last, close;

  assign msg_stall = q_stat.full;
  assign push      = msg_valid && !msg_stall;

  // Header sampling and classification of this beat
  always_comb begin
    start = (bytes_left == '0);
    if (msg.msg_size == '0) begin
      size_sat = mscrc_pkg::SIZE_W'(1);
    end else if (msg.msg_size > mscrc_pkg::SIZE_MAX) begin
      size_sat = mscrc_pkg::SIZE_MAX;
    end else begin
      size_sat = msg.msg_size;
    end
    size_round = {1'b0, size_sat} + (mscrc_pkg::SIZE_W + 1)'(7);
    left_cur   = start ? size_sat : bytes_left;
    pos        = start ? 3'd0 : byte_in_packet;
    idx        = start ? 8'd0 : packet_count;
    total      = start ? size_round[11:3] : total_latched;
    src        = start ? msg.src_id : src_latched;
    dest       = start ? msg.dest_id : dest_latched;
    bytes_left_next = left_cur - mscrc_pkg::SIZE_W'(1);
    last       = (bytes_left_next == '0);
    close      = (pos == 3'd7) || last;
  end

  assign op = '{data_byte: msg.data_byte, pos: pos, close: close, last: last,
                index: idx, total: total, src: src, dest: dest};

  // Message and packet counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left     <= '0;
      byte_in_packet <= 3'd0;
      packet_count   <= 8'd0;
      total_latched  <= 9'd0;
    end else if (push) begin
      bytes_left     <= bytes_left_next;
      byte_in_packet <= close ? 3'd0 : pos + 3'd1;
      packet_count   <= close ? idx + 8'd1 : idx;
      total_latched  <= total;
    end
  end

  // Header ids
  always_ff @(posedge clk) begin
    if (push) begin
      src_latched  <= src;
      dest_latched <= dest;
    end
  end

endmodule

FILE: rtl/mscrc_queue.sv
// ----------------------------------------------------------------------------
// mscrc_queue
// Short register queue that decouples the classifying front from the
// packet-building back.
// ----------------------------------------------------------------------------
module mscrc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mscrc_pkg::op_t     push_op,
  input  logic               pop,
  output mscrc_pkg::op_t     head,
  output mscrc_pkg::q_stat_t stat
);

  localparam int PTR_W = (mscrc_pkg::QDEPTH > 1) ? $clog2(mscrc_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(mscrc_pkg::QDEPTH + 1);

  mscrc_pkg::op_t   entries [mscrc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(mscrc_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mscrc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mscrc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

FILE: rtl/mscrc_back.sv
// ----------------------------------------------------------------------------
// mscrc_back
// Folds each byte into the packet CRC and payload, and loads the output
// register when a packet closes.
// ----------------------------------------------------------------------------
module mscrc_back (
  input  logic               clk,
  input  logic               rst,
  input  mscrc_pkg::op_t     head,
  input  mscrc_pkg::q_stat_t q_stat,
  output logic               pop,
  output logic               pkt_valid,
  input  logic               pkt_stall,
  output mscrc_pkg::pkt_t    pkt
);

  logic [15:0] crc_acc;
  logic [63:0] payload_buf;
  logic [15:0] crc_in, crc_next;
  logic [63:0] pl_in, payload_next;

  // A closing byte needs room in the output register
  assign pop = !q_stat.empty && (!head.close || !pkt_valid || !pkt_stall);

  // Byte fold; a byte at position zero starts a fresh packet
  always_comb begin
    crc_in       = (head.pos == 3'd0) ? mscrc_pkg::CRC_INIT : crc_acc;
    pl_in        = (head.pos == 3'd0) ? 64'd0 : payload_buf;
    crc_next     = mscrc_pkg::crc_byte(crc_in, head.data_byte);
    payload_next = pl_in | ({56'd0, head.data_byte} << {head.pos, 3'b000});
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      crc_acc     <= crc_next;
      payload_buf <= payload_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (pop && head.close) begin
      pkt_valid <= 1'b1;
    end else if (!pkt_stall) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.close) begin
      pkt.packet_index  <= head.index;
      pkt.total_packets <= head.total;
      pkt.src_id_out    <= head.src;
      pkt.dest_id_out   <= head.dest;
      pkt.data_length   <= {1'b0, head.pos} + 4'd1;
      pkt.crc           <= crc_next;
      pkt.payload       <= payload_next;
      pkt.last_packet   <= head.last;
    end
  end

endmodule

FILE: rtl/message_segmenter_crc16_unit.sv
// ----------------------------------------------------------------------------
// message_segmenter_crc16_unit
// Cuts a byte stream into packets of up to eight bytes, each with its own
// CRC-16/MODBUS, sequence number, ids and length.
//
//   channel | handshake             | beat   | carries
//   --------+-----------------------+--------+------------------------------
//   msg     | msg_valid / msg_stall | msg_t  | one message byte plus header
//   pkt     | pkt_valid / pkt_stall | pkt_t  | one finished packet
//
// One byte is taken every cycle while msg_stall is low; the CRC update for a
// byte is done in the back end. A packet appears on pkt after its closing
// byte has passed the queue and then the output register.
// Reset clears counters, queue and output valid; no clearing pass is needed.
// A stalled pkt fills the two-entry queue, after which msg_stall rises.
// ----------------------------------------------------------------------------
module message_segmenter_crc16_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            msg_valid,
  output logic            msg_stall,
  input  mscrc_pkg::msg_t msg,
  output logic            pkt_valid,
  input  logic            pkt_stall,
  output mscrc_pkg::pkt_t pkt
);

  mscrc_pkg::q_stat_t q_stat;
  mscrc_pkg::op_t     push_op, head;
  logic               push, pop;

  mscrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .q_stat    (q_stat),
    .push      (push),
    .op        (push_op)
  );

  mscrc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  mscrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt)
  );

endmodule

FILE: rtl/mscrc_checker.sv
// ----------------------------------------------------------------------------
// mscrc_checker
// Port-level checks on the segmenter's packet output.
// ----------------------------------------------------------------------------
module mscrc_checker (
  input logic            clk,
  input logic            rst,
  input logic            pkt_valid,
  input logic            pkt_stall,
  input mscrc_pkg::pkt_t pkt
);

  // No packet straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !pkt_valid)
    else $error("packet valid after reset");

  // Held packet stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt))
    else $error("stalled packet changed");

  // Only the final packet may be short
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt.last_packet |-> pkt.data_length == 4'd8)
    else $error("short packet before the last one");

  // Length within one to eight
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    pkt_valid |-> pkt.data_length != 4'd0 && pkt.data_length <= 4'd8)
    else $error("packet length out of range");

  // Sequence number below the packet count
  a_index: assert property (@(posedge clk) disable iff (rst)
    pkt_valid |-> {1'b0, pkt.packet_index} < pkt.total_packets)
    else $error("packet index not below total");

endmodule

bind message_segmenter_crc16_unit mscrc_checker u_mscrc_checker (.*);
